[sv/metc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package metc_pkg;

  localparam logic [1:0] FN_RISE   = 2'd0;
  localparam logic [1:0] FN_FALL   = 2'd1;
  localparam logic [1:0] FN_BUTTON = 2'd2;

  localparam logic [2:0] EL_NONE      = 3'd0;
  localparam logic [2:0] EL_CAL       = 3'd1;
  localparam logic [2:0] EL_EOC       = 3'd2;
  localparam logic [2:0] EL_EOW       = 3'd3;
  localparam logic [2:0] EL_BADSPACE  = 3'd4;
  localparam logic [2:0] EL_DOT       = 3'd5;
  localparam logic [2:0] EL_DASH      = 3'd6;
  localparam logic [2:0] EL_BADPULSE  = 3'd7;

  localparam logic [2:0] PH_CAL_RISE = 3'd0;
  localparam logic [2:0] PH_CAL_FALL = 3'd1;
  localparam logic [2:0] PH_EOC_RISE = 3'd2;
  localparam logic [2:0] PH_EOC_FALL = 3'd3;
  localparam logic [2:0] PH_DEC_RISE = 3'd4;
  localparam logic [2:0] PH_DEC_FALL = 3'd5;

  // range check select: 1, 3 or 7 dots
  localparam logic [1:0] SEL_X1 = 2'd0;
  localparam logic [1:0] SEL_X3 = 2'd1;
  localparam logic [1:0] SEL_X7 = 2'd2;

  localparam logic [7:0] TOL_X1 = 8'd20;
  localparam logic [7:0] TOL_X3 = 8'd60;
  localparam logic [7:0] TOL_X7 = 8'd140;

  localparam int RATIO_SCALE = 100;
  localparam int RATIO_LO    = 34;
  localparam int RATIO_HI    = 297;

  typedef struct packed {
    logic       load_in;
    logic       store_rise;
    logic       store_fall;
    logic       cand_take_width;
    logic       cand_clear;
    logic       dot_take_cand;
    logic       dot_take_width;
    logic       div_start;
    logic       div_step;
    logic       centre_load;
    logic [1:0] chk_sel;
    logic       dur_pulse;
    logic       out_load;
    logic [2:0] element;
    logic [2:0] phase;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cand_zero;
    logic       width_zero;
    logic       div_last;
    logic       q_low;
    logic       q_high;
    logic       hit;
    logic       can_load;
  } sts_t;

endpackage

`default_nettype wire

[sv/metc_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface metc_ev_if #(
  parameter int TIME_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [TIME_WIDTH-1:0] timestamp;

  modport source (output valid, func, timestamp, input ready);
  modport sink   (input valid, func, timestamp, output ready);
endinterface

interface metc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  element;
  logic [15:0] dot_length;
  logic [2:0]  phase;

  modport source (output valid, element, dot_length, phase, input ready);
  modport sink   (input valid, element, dot_length, phase, output ready);
endinterface

`default_nettype wire

[sv/morse_element_timing_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none

// Morse element timing classifier.
// ev carries one request per keyed-signal event: func (rise, fall, button)
// and a free-running timestamp of TIME_WIDTH bits. res returns exactly one
// result per request: element code, current dot length and phase.
// Each request is handled alone; the next one is taken when the controller
// is back in idle. Every request passes through dispatch and finish; a
// calibration pulse that ends early also passes the calibration check, a
// space or pulse classification runs one or two range checks (each a centre
// load and a compare), and a calibration pulse that needs the ratio runs the
// restoring divider, one quotient bit per cycle over TIME_WIDTH + 7 quotient
// bits. The result enters the output register as the controller goes idle.
// Reset clears the phase to calibration, both edge times, the candidate
// pulse and the dot length. When the receiver stalls, the result waits in
// the output register; one further request is accepted and processed, and
// its result holds in the controller until the register frees.
module morse_element_timing_classifier #(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  metc_ev_if.sink   ev,
  metc_res_if.source res
);
  import metc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign ev.ready = in_ready;

  metc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ev.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  metc_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func_in    (ev.func),
    .ts_in      (ev.timestamp),
    .res_ready  (res.ready),
    .res_valid  (res.valid),
    .element    (res.element),
    .dot_length (res.dot_length),
    .phase      (res.phase)
  );

endmodule

`default_nettype wire

[sv/metc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module metc_dp #(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire metc_pkg::cmd_t        cmd,
  output metc_pkg::sts_t             sts,
  input  wire logic [1:0]            func_in,
  input  wire logic [TIME_WIDTH-1:0] ts_in,
  input  wire logic                  res_ready,
  output logic                       res_valid,
  output logic [2:0]                 element,
  output logic [15:0]                dot_length,
  output logic [2:0]                 phase
);
  import metc_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int QW = TW + 7;
  localparam int EW = TW + 4;
  localparam int CW = $clog2(QW);

  logic [1:0]    func_r;
  logic [TW-1:0] ts_r;
  logic [TW-1:0] rise;
  logic [TW-1:0] fall;
  logic [TW-1:0] cand;
  logic [TW-1:0] dot;

  logic [QW-1:0] dvd;
  logic [QW-1:0] quo;
  logic [TW-1:0] rem;
  logic [CW-1:0] cnt;

  logic [EW-1:0] centre;
  logic [1:0]    sel;

  logic [TW-1:0] width;
  logic [TW-1:0] gap;
  logic [TW-1:0] dur;
  logic [QW-1:0] cand_q;
  logic [QW-1:0] dvd_init;
  logic [TW:0]   rem_sh;
  logic [TW:0]   dvs_ext;
  logic          ge;
  logic [TW:0]   rem_sub;
  logic [EW-1:0] dot_e;
  logic [EW-1:0] centre_next;
  logic [EW-1:0] dur_e;
  logic [EW-1:0] tol_e;
  logic [7:0]    tol;
  logic [TW+15:0] dot_wide;

  assign width    = fall - rise;
  assign gap      = rise - fall;
  assign dur      = cmd.dur_pulse ? width : gap;

  // 100 * candidate as shifts
  assign cand_q   = QW'(cand);
  assign dvd_init = (cand_q << 6) + (cand_q << 5) + (cand_q << 2);

  assign rem_sh   = {rem, dvd[QW-1]};
  assign dvs_ext  = {1'b0, width};
  assign ge       = rem_sh >= dvs_ext;
  assign rem_sub  = rem_sh - dvs_ext;

  assign dot_e = EW'(dot);
  always_comb begin
    case (cmd.chk_sel)
      SEL_X3:  centre_next = dot_e + (dot_e << 1);
      SEL_X7:  centre_next = (dot_e << 3) - dot_e;
      default: centre_next = dot_e;
    endcase
  end

  always_comb begin
    case (sel)
      SEL_X3:  tol = TOL_X3;
      SEL_X7:  tol = TOL_X7;
      default: tol = TOL_X1;
    endcase
  end

  assign dur_e = EW'(dur);
  assign tol_e = EW'(tol);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= func_in;
      ts_r   <= ts_in;
    end
    if (cmd.div_start) begin
      dvd <= dvd_init;
      quo <= '0;
      rem <= '0;
      cnt <= CW'(QW - 1);
    end else if (cmd.div_step) begin
      dvd <= {dvd[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
      rem <= ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      cnt <= cnt - 1'b1;
    end
    if (cmd.centre_load) begin
      centre <= centre_next;
      sel    <= cmd.chk_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise <= '0;
      fall <= '0;
      cand <= '0;
      dot  <= '0;
    end else begin
      if (cmd.store_rise) rise <= ts_r;
      if (cmd.store_fall) fall <= ts_r;
      if (cmd.cand_clear) begin
        cand <= '0;
      end else if (cmd.cand_take_width) begin
        cand <= width;
      end
      if (cmd.dot_take_cand) begin
        dot <= cand;
      end else if (cmd.dot_take_width) begin
        dot <= width;
      end
    end
  end

  assign dot_wide = {16'b0, dot};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      element    <= cmd.element;
      phase      <= cmd.phase;
      dot_length <= dot_wide[15:0];
    end
  end

  assign sts.func       = func_r;
  assign sts.cand_zero  = cand == '0;
  assign sts.width_zero = width == '0;
  assign sts.div_last   = cnt == '0;
  assign sts.q_low      = quo <= QW'(RATIO_LO);
  assign sts.q_high     = quo >= QW'(RATIO_HI);
  assign sts.hit        = (dur_e <= centre + tol_e) && (dur_e + tol_e >= centre);
  assign sts.can_load   = !res_valid || res_ready;

endmodule

`default_nettype wire

[sv/metc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module metc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire metc_pkg::sts_t sts,
  output metc_pkg::cmd_t      cmd
);
  import metc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_CAL      = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_CAL_END  = 4'd4;
  localparam logic [3:0] S_CEN0     = 4'd5;
  localparam logic [3:0] S_CHK0     = 4'd6;
  localparam logic [3:0] S_CEN1     = 4'd7;
  localparam logic [3:0] S_CHK1     = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [2:0] el;
  logic [2:0] el_next;
  logic       is_space;
  logic       is_space_next;
  logic [2:0] space_phase;

  // phase after a space, given the element found
  always_comb begin
    if (phase == PH_EOC_RISE) begin
      space_phase = (el_next == EL_EOC) ? PH_DEC_FALL : PH_EOC_FALL;
    end else begin
      space_phase = PH_DEC_FALL;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    el_next       = el;
    is_space_next = is_space;
    cmd           = '0;
    cmd.element   = el;
    cmd.phase     = phase;
    cmd.dur_pulse = !is_space;
    in_ready      = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        el_next    = EL_NONE;
        state_next = S_FINISH;
        case (sts.func)
          FN_BUTTON: begin
            if (phase >= PH_EOC_RISE) begin
              phase_next     = PH_CAL_RISE;
              cmd.cand_clear = 1'b1;
            end
          end
          FN_RISE: begin
            unique case (phase) inside
              PH_CAL_RISE: begin
                cmd.store_rise = 1'b1;
                phase_next     = PH_CAL_FALL;
              end
              PH_EOC_RISE, PH_DEC_RISE: begin
                cmd.store_rise = 1'b1;
                is_space_next  = 1'b1;
                state_next     = S_CEN0;
              end
              default: ;
            endcase
          end
          FN_FALL: begin
            unique case (phase)
              PH_CAL_FALL: begin
                cmd.store_fall = 1'b1;
                state_next     = S_CAL;
              end
              PH_EOC_FALL: begin
                cmd.store_fall = 1'b1;
                phase_next     = PH_EOC_RISE;
              end
              PH_DEC_FALL: begin
                cmd.store_fall = 1'b1;
                is_space_next  = 1'b0;
                state_next     = S_CEN0;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_CAL: begin
        state_next = S_FINISH;
        if (sts.cand_zero) begin
          cmd.cand_take_width = 1'b1;
          phase_next          = PH_CAL_RISE;
        end else if (sts.width_zero) begin
          cmd.cand_clear = 1'b1;
          phase_next     = PH_CAL_RISE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_CAL_END;
      end
      S_CAL_END: begin
        state_next = S_FINISH;
        if (sts.q_low) begin
          cmd.dot_take_cand = 1'b1;
          el_next           = EL_CAL;
          phase_next        = PH_EOC_RISE;
        end else if (sts.q_high) begin
          cmd.dot_take_width = 1'b1;
          el_next            = EL_CAL;
          phase_next         = PH_EOC_RISE;
        end else begin
          cmd.cand_take_width = 1'b1;
          phase_next          = PH_CAL_RISE;
        end
      end
      S_CEN0: begin
        cmd.centre_load = 1'b1;
        cmd.chk_sel     = is_space ? SEL_X3 : SEL_X1;
        state_next      = S_CHK0;
      end
      S_CHK0: begin
        if (sts.hit) begin
          el_next    = is_space ? EL_EOC : EL_DOT;
          phase_next = is_space ? space_phase : PH_DEC_RISE;
          state_next = S_FINISH;
        end else begin
          state_next = S_CEN1;
        end
      end
      S_CEN1: begin
        cmd.centre_load = 1'b1;
        cmd.chk_sel     = is_space ? SEL_X7 : SEL_X3;
        state_next      = S_CHK1;
      end
      S_CHK1: begin
        if (is_space) begin
          el_next = sts.hit ? EL_EOW : EL_BADSPACE;
        end else begin
          el_next = sts.hit ? EL_DASH : EL_BADPULSE;
        end
        phase_next = is_space ? space_phase : PH_DEC_RISE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.can_load) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_CAL_RISE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    el       <= el_next;
    is_space <= is_space_next;
  end

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state == S_DISPATCH)
    else $error("accepted request not dispatched");

  a_div_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !sts.div_last) |=> state == S_DIV)
    else $error("divider left early");

  a_cal_phase: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.element == EL_CAL) |-> cmd.phase == PH_EOC_RISE)
    else $error("calibration result with wrong phase");

  a_eoc_phase: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.element == EL_EOC) |-> cmd.phase == PH_DEC_FALL)
    else $error("end of character with wrong phase");

  a_pulse_phase: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && (cmd.element == EL_DOT || cmd.element == EL_DASH ||
                      cmd.element == EL_BADPULSE)) |-> cmd.phase == PH_DEC_RISE)
    else $error("pulse result with wrong phase");

endmodule

`default_nettype wire

[tb/sv/tb_morse_element_timing_classifier.sv]
`timescale 1ns / 1ps

module tb_morse_element_timing_classifier;
  import metc_pkg::*;

  localparam logic [1:0] FN_SPARE = 2'd3;

  localparam int RATIO_FLOOR    = 34;
  localparam int RATIO_CEIL     = 297;
  localparam int TOL_DOT        = 20;
  localparam int TOL_CHAR       = 60;
  localparam int TOL_WORD       = 140;
  localparam int RANDOM_EVENTS  = 1620;
  localparam int SQUEEZE_AT     = 500;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int DIR_N          = 30;

  typedef struct packed {
    logic [2:0]  element;
    logic [15:0] dot_length;
    logic [2:0]  phase;
  } elem_res_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] stamp;
    logic        typed;
    elem_res_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  metc_ev_if #(.TIME_WIDTH(16)) ev ();
  metc_res_if res ();

  morse_element_timing_classifier #(.TIME_WIDTH(16)) dut (
    .clk(clk),
    .rst(rst),
    .ev(ev),
    .res(res)
  );

  // keyer state as the block should hold it
  logic [2:0]  key_phase  = PH_CAL_RISE;
  logic [15:0] rise_stamp = '0;
  logic [15:0] fall_stamp = '0;
  logic [15:0] cand_width = '0;
  logic [15:0] dot_len    = '0;

  elem_res_t expected_elems[$];
  int        mismatches = 0;
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;
  bit        squeeze_rx = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{FN_BUTTON, 16'h0000, 1'b1, '{EL_NONE, 16'd0, PH_CAL_RISE}},
    '{FN_SPARE,  16'hFFFF, 1'b1, '{EL_NONE, 16'd0, PH_CAL_RISE}},
    '{FN_FALL,   16'h0000, 1'b1, '{EL_NONE, 16'd0, PH_CAL_RISE}},
    '{FN_RISE,   16'hFFF0, 1'b1, '{EL_NONE, 16'd0, PH_CAL_FALL}},
    '{FN_FALL,   16'hFFF0, 1'b0, '0},
    '{FN_RISE,   16'hFFF0, 1'b0, '0},
    '{FN_FALL,   16'h0010, 1'b0, '0},
    '{FN_RISE,   16'h0100, 1'b0, '0},
    '{FN_FALL,   16'h0100, 1'b0, '0},
    '{FN_RISE,   16'h0200, 1'b0, '0},
    '{FN_FALL,   16'h0264, 1'b0, '0},
    '{FN_RISE,   16'h0300, 1'b0, '0},
    '{FN_FALL,   16'h03C8, 1'b0, '0},
    '{FN_RISE,   16'h1000, 1'b0, '0},
    '{FN_FALL,   16'h1258, 1'b1, '{EL_CAL, 16'd200, PH_EOC_RISE}},
    '{FN_RISE,   16'h14EC, 1'b0, '0},
    '{FN_FALL,   16'h15C8, 1'b0, '0},
    '{FN_RISE,   16'h1B40, 1'b0, '0},
    '{FN_FALL,   16'h1D98, 1'b0, '0},
    '{FN_RISE,   16'h2180, 1'b0, '0},
    '{FN_FALL,   16'h2415, 1'b0, '0},
    '{FN_BUTTON, 16'h0000, 1'b1, '{EL_NONE, 16'd200, PH_CAL_RISE}},
    '{FN_RISE,   16'hFF00, 1'b0, '0},
    '{FN_FALL,   16'h002C, 1'b0, '0},
    '{FN_RISE,   16'h0100, 1'b0, '0},
    '{FN_FALL,   16'h0101, 1'b0, '0},
    '{FN_RISE,   16'h01C9, 1'b0, '0},
    '{FN_FALL,   16'h01D0, 1'b0, '0},
    '{FN_RISE,   16'h01D0, 1'b0, '0},
    '{FN_FALL,   16'h01D0, 1'b0, '0}
  };

  function automatic bit near_multiple(logic [15:0] dur, int mult, int tol);
    longint centre = longint'(dot_len) * mult;
    return longint'(dur) <= centre + tol && longint'(dur) >= centre - tol;
  endfunction

  function automatic logic [2:0] space_code();
    logic [15:0] gap = rise_stamp - fall_stamp;
    if (near_multiple(gap, 3, TOL_CHAR)) return EL_EOC;
    if (near_multiple(gap, 7, TOL_WORD)) return EL_EOW;
    return EL_BADSPACE;
  endfunction

  task automatic classify_event(input logic [1:0] fn, input logic [15:0] stamp,
                                output elem_res_t outcome, output bit acted);
    logic [66:0] prior;
    logic [2:0]  el;
    logic [15:0] width;
    int unsigned ratio;
    prior = {key_phase, rise_stamp, fall_stamp, cand_width, dot_len};
    el = EL_NONE;
    if (key_phase > PH_DEC_FALL) key_phase = PH_CAL_RISE;
    case (fn)
      FN_BUTTON: begin
        if (key_phase >= PH_EOC_RISE) begin
          key_phase = PH_CAL_RISE;
          cand_width = '0;
        end
      end
      FN_RISE: begin
        case (key_phase)
          PH_CAL_RISE: begin
            rise_stamp = stamp;
            key_phase = PH_CAL_FALL;
          end
          PH_EOC_RISE: begin
            rise_stamp = stamp;
            el = space_code();
            key_phase = (el == EL_EOC) ? PH_DEC_FALL : PH_EOC_FALL;
          end
          PH_DEC_RISE: begin
            rise_stamp = stamp;
            el = space_code();
            key_phase = PH_DEC_FALL;
          end
          default: ;
        endcase
      end
      FN_FALL: begin
        case (key_phase)
          PH_CAL_FALL: begin
            fall_stamp = stamp;
            width = fall_stamp - rise_stamp;
            if (cand_width == '0) begin
              cand_width = width;
            end else if (width == '0) begin
              cand_width = '0;
            end else begin
              ratio = (32'd100 * cand_width) / width;
              if (ratio <= RATIO_FLOOR) begin
                dot_len = cand_width;
                el = EL_CAL;
              end else if (ratio >= RATIO_CEIL) begin
                dot_len = width;
                el = EL_CAL;
              end else begin
                cand_width = width;
              end
            end
            key_phase = (el == EL_CAL) ? PH_EOC_RISE : PH_CAL_RISE;
          end
          PH_EOC_FALL: begin
            fall_stamp = stamp;
            key_phase = PH_EOC_RISE;
          end
          PH_DEC_FALL: begin
            fall_stamp = stamp;
            width = fall_stamp - rise_stamp;
            key_phase = PH_DEC_RISE;
            if (near_multiple(width, 1, TOL_DOT)) el = EL_DOT;
            else if (near_multiple(width, 3, TOL_CHAR)) el = EL_DASH;
            else el = EL_BADPULSE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    outcome = '{el, dot_len, key_phase};
    acted = (el != EL_NONE) ||
            (prior != {key_phase, rise_stamp, fall_stamp, cand_width, dot_len});
  endtask

  function automatic int pick_gap();
    int roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic int pick_unit();
    int roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 300);
    if (roll < 95) return $urandom_range(300, 3000);
    return $urandom_range(3000, 9000);
  endfunction

  function automatic logic [15:0] jittered(int unit, int mult, int slack);
    int dur = unit * mult + int'($urandom_range(0, 2 * slack)) - slack;
    return (dur < 0) ? 16'd0 : 16'(dur);
  endfunction

  function void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic offer_event(input logic [1:0] fn, input logic [15:0] stamp,
                             input bit typed, input elem_res_t want, output bit acted);
    int        gap;
    elem_res_t predicted;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      ev.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev.valid <= 1'b1;
    ev.func <= fn;
    ev.timestamp <= stamp;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
    classify_event(fn, stamp, predicted, acted);
    expected_elems.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    elem_res_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_elems.size() == 0) begin
        flag_error($sformatf("unexpected result: element %0d dot %0d phase %0d",
                             res.element, res.dot_length, res.phase));
      end else begin
        want = expected_elems.pop_front();
        if (res.element !== want.element || res.dot_length !== want.dot_length ||
            res.phase !== want.phase) begin
          flag_error($sformatf(
              "mismatch: element %0d/%0d dot %0d/%0d phase %0d/%0d (exp/act)",
              want.element, res.element, want.dot_length, res.dot_length,
              want.phase, res.phase));
        end
      end
    end
  end

  initial begin
    int stall;
    res.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : pick_gap();
      if (squeeze_rx) begin
        squeeze_rx = 1'b0;
        stall = SQUEEZE_CYCLES;
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  initial begin
    #50_000_000;
    $display("tb_morse_element_timing_classifier: errors");
    $finish;
  end

  initial begin
    logic [1:0]  fn;
    logic [15:0] stamp;
    logic [15:0] now;
    int          unit;
    int          base;
    int          mult;
    int          slack;
    int          roll;
    int          done;
    bit          acted;
    bit          squeezed;
    ev.valid = 1'b0;
    ev.func = FN_RISE;
    ev.timestamp = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer_event(dir_rows[i].func, dir_rows[i].stamp, dir_rows[i].typed,
                  dir_rows[i].want, acted);
    end

    now = 16'($urandom);
    unit = pick_unit();
    done = 0;
    squeezed = 1'b0;
    while (done < RANDOM_EVENTS) begin
      if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
      if (done == SQUEEZE_AT && !squeezed) begin
        squeezed = 1'b1;
        squeeze_rx = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        fn = FN_BUTTON;
        stamp = now + 16'($urandom_range(0, 50));
        unit = pick_unit();
      end else if (roll < 8) begin
        fn = 2'($urandom_range(0, 3));
        stamp = 16'($urandom);
      end else begin
        fn = key_phase[0] ? FN_FALL : FN_RISE;
        if (key_phase < PH_EOC_RISE) begin
          // calibration: dot/dash pulse pairs with some spread
          if (fn == FN_FALL)
            stamp = now + jittered(unit, $urandom_range(0, 1) ? 3 : 1, unit / 8 + 1);
          else
            stamp = now + jittered(unit, $urandom_range(1, 3), unit / 4 + 1);
        end else if ($urandom_range(0, 9) == 0) begin
          stamp = 16'($urandom);
        end else begin
          base = (dot_len == '0) ? unit : int'(dot_len);
          if (fn == FN_FALL) begin
            mult = $urandom_range(0, 1) ? 3 : 1;
            slack = (mult == 1) ? TOL_DOT : TOL_CHAR;
          end else begin
            roll = $urandom_range(0, 2);
            mult = (roll == 0) ? 1 : (roll == 1) ? 3 : 7;
            slack = (mult == 1) ? TOL_DOT : (mult == 3) ? TOL_CHAR : TOL_WORD;
          end
          stamp = now + jittered(base, mult, slack + 8);
        end
      end
      now = stamp;
      offer_event(fn, stamp, 1'b0, '0, acted);
      if (acted) done++;
    end
    ev.valid <= 1'b0;

    while (expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_elems.size() == 0)
      $display("tb_morse_element_timing_classifier: clean");
    else
      $display("tb_morse_element_timing_classifier: errors");
    $finish;
  end

endmodule
